/* sv/rtal_pkg.sv */
// Shared constants and types for the card allow list.
`default_nettype none

package rtal_pkg;

  localparam int unsigned UID_W = 32;
  localparam int unsigned COUNT_OUT_W = 5;
  localparam int unsigned TABLE_ENTRIES_DEF = 16;

  localparam logic [UID_W-1:0] MASTER_RESET = {8'hC3, 8'h66, 8'hCB, 8'h18};

  localparam logic ACT_QUERY  = 1'b0;
  localparam logic ACT_TOGGLE = 1'b1;

  typedef enum logic [1:0] {
    CHG_NONE    = 2'd0,
    CHG_ADDED   = 2'd1,
    CHG_REMOVED = 2'd2,
    CHG_FULL    = 2'd3
  } change_code_t;

  typedef struct packed {
    logic go;
    logic toggle;
  } tbl_req_t;

  typedef struct packed {
    logic         listed;
    change_code_t code;
  } tbl_rsp_t;

endpackage

`default_nettype wire

/* sv/rtal_if.sv */
// Valid/ready channel interfaces for the input, result and configuration words.
`default_nettype none

interface rtal_in_if;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [rtal_pkg::UID_W-1:0] card_uid;

  modport source (output valid, output action, output card_uid, input ready);
  modport sink (input valid, input action, input card_uid, output ready);
endinterface

interface rtal_out_if;
  logic                           valid;
  logic                           ready;
  logic                           is_master;
  logic                           was_listed;
  logic [1:0]                     change_code;
  logic [rtal_pkg::COUNT_OUT_W-1:0] entry_count;

  modport source (output valid, output is_master, output was_listed, output change_code,
                  output entry_count, input ready);
  modport sink (input valid, input is_master, input was_listed, input change_code,
                input entry_count, output ready);
endinterface

interface rtal_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [rtal_pkg::UID_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/rfid_tag_allow_list.sv */
// Card identifier allow list: top level with input register, table and result register.
//
// Input channel in_ch carries one word per card: action (query or toggle) and card_uid.
// Result channel out_ch returns one word per input word: is_master, was_listed,
// change_code and entry_count (valid entries after the word).
// Configuration channel cfg_ch writes master_uid; it is always ready and takes
// effect on the next word processed. Write it only while no word is in flight.
// A word accepted on in_ch goes into the input register, then into the result register that drives out_ch.
// Throughput: one word per cycle while out_ch takes results; the parallel compare over all entries and the
// lowest free slot pick sit between the input register and the result register.
// A stalled out_ch holds its word; the input register then fills and in_ch.ready
// drops until the result is taken.
// Reset (rst_n low, synchronous): empties the table, zeroes the count, restores
// master_uid to C3 66 CB 18 and drops both register stages.
`default_nettype none

module rfid_tag_allow_list #(
  parameter int unsigned TABLE_ENTRIES = rtal_pkg::TABLE_ENTRIES_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  rtal_in_if.sink    in_ch,
  rtal_out_if.source out_ch,
  rtal_cfg_if.sink   cfg_ch
);

  logic                            s1_valid_r;
  logic                            s1_action_r;
  logic [rtal_pkg::UID_W-1:0]      s1_uid_r;
  logic [rtal_pkg::UID_W-1:0]      master_r;

  logic                            out_valid_r;
  logic                            out_is_master_r;
  logic                            out_was_listed_r;
  rtal_pkg::change_code_t          out_code_r;
  logic [rtal_pkg::COUNT_OUT_W-1:0] out_count_r;

  logic                            advance;
  rtal_pkg::tbl_req_t              tbl_req;
  rtal_pkg::tbl_rsp_t              tbl_rsp;
  logic [rtal_pkg::COUNT_OUT_W-1:0] count_nxt;

  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  assign tbl_req.go     = s1_valid_r && advance;
  assign tbl_req.toggle = (s1_action_r == rtal_pkg::ACT_TOGGLE);

  rtal_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (tbl_req),
    .uid       (s1_uid_r),
    .rsp       (tbl_rsp),
    .count_out (count_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_r    <= rtal_pkg::MASTER_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        master_r <= cfg_ch.data;
      end
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_action_r <= in_ch.action;
      s1_uid_r    <= in_ch.card_uid;
    end
    if (tbl_req.go) begin
      out_is_master_r  <= (s1_uid_r == master_r);
      out_was_listed_r <= tbl_rsp.listed;
      out_code_r       <= tbl_rsp.code;
      out_count_r      <= count_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.is_master   = out_is_master_r;
  assign out_ch.was_listed  = out_was_listed_r;
  assign out_ch.change_code = out_code_r;
  assign out_ch.entry_count = out_count_r;

endmodule

`default_nettype wire

/* sv/rtal_table.sv */
// Identifier table with valid marks, parallel match, lowest free slot pick and count.
`default_nettype none

module rtal_table #(
  parameter int unsigned TABLE_ENTRIES = rtal_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire rtal_pkg::tbl_req_t               req,
  input  wire logic [rtal_pkg::UID_W-1:0]       uid,
  output rtal_pkg::tbl_rsp_t                    rsp,
  output logic [rtal_pkg::COUNT_OUT_W-1:0]      count_out
);

  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  logic [rtal_pkg::UID_W-1:0] uid_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]   valid_r, valid_nxt;
  logic [CW-1:0]              count_r, count_nxt;

  logic [TABLE_ENTRIES-1:0] hit_vec, hit_low, free_vec, free_low;
  logic                     listed, full, do_add;
  logic [31:0]              count_ext;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_vec[i] = valid_r[i] && (uid_r[i] == uid);
    end
  end

  assign free_vec = ~valid_r;
  assign hit_low  = hit_vec & (~hit_vec + TABLE_ENTRIES'(1));
  assign free_low = free_vec & (~free_vec + TABLE_ENTRIES'(1));
  assign listed   = |hit_vec;
  assign full     = &valid_r;
  assign do_add   = req.go && req.toggle && !listed && !full;

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    rsp.listed = listed;
    rsp.code   = rtal_pkg::CHG_NONE;
    if (req.toggle) begin
      if (listed) begin
        rsp.code = rtal_pkg::CHG_REMOVED;
      end else if (full) begin
        rsp.code = rtal_pkg::CHG_FULL;
      end else begin
        rsp.code = rtal_pkg::CHG_ADDED;
      end
    end
    if (req.go && req.toggle) begin
      if (listed) begin
        valid_nxt = valid_r & ~hit_low;
        count_nxt = count_r - CW'(1);
      end else if (!full) begin
        valid_nxt = valid_r | free_low;
        count_nxt = count_r + CW'(1);
      end
    end
  end

  assign count_ext = 32'(count_nxt);
  assign count_out = count_ext[rtal_pkg::COUNT_OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (do_add && free_low[i]) begin
        uid_r[i] <= uid;
      end
    end
  end

endmodule

`default_nettype wire

/* tb/tb_rfid_tag_allow_list.sv */
// Testbench for the card allow list: table predictor, scoreboard and handshake drivers.
`timescale 1ns / 100ps

module tb_rfid_tag_allow_list;

  localparam int TABLE_SLOTS = rtal_pkg::TABLE_ENTRIES_DEF;
  localparam int POOL_SIZE = 20;

  typedef struct packed {
    logic                             is_master;
    logic                             was_listed;
    rtal_pkg::change_code_t           code;
    logic [rtal_pkg::COUNT_OUT_W-1:0] count;
  } card_result_t;

  class allow_list_scoreboard;
    logic [rtal_pkg::UID_W-1:0] master;
    logic [rtal_pkg::UID_W-1:0] stored_uid [TABLE_SLOTS];
    bit                         stored_valid [TABLE_SLOTS];
    int unsigned                live_count;
    card_result_t               expected_results [$];
    int unsigned                mismatches;

    function new();
      master = rtal_pkg::MASTER_RESET;
      foreach (stored_valid[i]) stored_valid[i] = 1'b0;
      live_count = 0;
      mismatches = 0;
    endfunction

    function void note_card(logic act, logic [rtal_pkg::UID_W-1:0] uid);
      card_result_t r;
      int hit;
      int slot;
      hit = -1;
      slot = -1;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (stored_valid[i] && stored_uid[i] == uid && hit < 0) hit = i;
        if (!stored_valid[i] && slot < 0) slot = i;
      end
      r.is_master = (uid == master);
      r.was_listed = (hit >= 0);
      r.code = rtal_pkg::CHG_NONE;
      if (act == rtal_pkg::ACT_TOGGLE) begin
        if (hit >= 0) begin
          stored_valid[hit] = 1'b0;
          if (live_count > 0) live_count--;
          r.code = rtal_pkg::CHG_REMOVED;
        end else if (slot >= 0) begin
          stored_uid[slot] = uid;
          stored_valid[slot] = 1'b1;
          live_count++;
          r.code = rtal_pkg::CHG_ADDED;
        end else begin
          r.code = rtal_pkg::CHG_FULL;
        end
      end
      r.count = live_count[rtal_pkg::COUNT_OUT_W-1:0];
      expected_results.push_back(r);
    endfunction

    function void check_word(card_result_t got);
      card_result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: unexpected result master=%0b listed=%0b code=%0d count=%0d",
                   got.is_master, got.was_listed, got.code, got.count);
        return;
      end
      want = expected_results.pop_front();
      if (got.is_master !== want.is_master || got.was_listed !== want.was_listed ||
          got.code !== want.code || got.count !== want.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected master=%0b listed=%0b code=%0d count=%0d, got %0b %0b %0d %0d",
                   want.is_master, want.was_listed, want.code, want.count,
                   got.is_master, got.was_listed, got.code, got.count);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   sender_pct;
  int   sink_pct;

  allow_list_scoreboard book;
  logic [rtal_pkg::UID_W-1:0] card_pool [POOL_SIZE];

  rtal_in_if  in_ch ();
  rtal_out_if out_ch ();
  rtal_cfg_if cfg_ch ();

  rfid_tag_allow_list dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      book.check_word('{out_ch.is_master, out_ch.was_listed,
                        rtal_pkg::change_code_t'(out_ch.change_code), out_ch.entry_count});
    out_ch.ready <= !($urandom_range(99) < sink_pct);
  end

  task automatic send_card(logic act, logic [rtal_pkg::UID_W-1:0] uid);
    while ($urandom_range(99) < sender_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.card_uid <= uid;
    do @(posedge clk); while (!in_ch.ready);
    book.note_card(act, uid);
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    while (book.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_master(logic [rtal_pkg::UID_W-1:0] value);
    hold_until_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    book.master = value;
  endtask

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int pick;
    logic [rtal_pkg::UID_W-1:0] uid;
    book = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = rtal_pkg::ACT_QUERY;
    in_ch.card_uid = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    sender_pct = 0;
    sink_pct = 0;
    card_pool[0] = '0;
    card_pool[1] = '1;
    card_pool[2] = rtal_pkg::MASTER_RESET;
    for (int i = 3; i < POOL_SIZE; i++) card_pool[i] = $urandom();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_card(rtal_pkg::ACT_QUERY, card_pool[0]);
    send_card(rtal_pkg::ACT_QUERY, rtal_pkg::MASTER_RESET);
    for (int i = 0; i < TABLE_SLOTS; i++) send_card(rtal_pkg::ACT_TOGGLE, card_pool[i]);
    send_card(rtal_pkg::ACT_QUERY, card_pool[1]);
    send_card(rtal_pkg::ACT_TOGGLE, card_pool[16]);
    send_card(rtal_pkg::ACT_TOGGLE, card_pool[2]);
    send_card(rtal_pkg::ACT_TOGGLE, card_pool[16]);
    send_card(rtal_pkg::ACT_TOGGLE, card_pool[0]);

    for (int p = 0; p < 6; p++) begin
      case (p)
        1: write_master('0);
        2: write_master('1);
        3: write_master(card_pool[5]);
        4: write_master($urandom());
        5: write_master(rtal_pkg::MASTER_RESET);
        default: hold_until_drained();
      endcase
      case (p)
        1: begin
          sender_pct = 59;
          sink_pct = 0;
        end
        2: begin
          sender_pct = 0;
          sink_pct = 59;
        end
        3, 5: begin
          sender_pct = 37;
          sink_pct = 37;
        end
        default: begin
          sender_pct = 0;
          sink_pct = 0;
        end
      endcase
      for (int n = 0; n < 88; n++) begin
        pick = $urandom_range(99);
        if (pick < 10) uid = $urandom();
        else if (pick < 22) uid = book.master;
        else uid = card_pool[$urandom_range(POOL_SIZE - 1)];
        send_card(($urandom_range(99) < 60) ? rtal_pkg::ACT_TOGGLE : rtal_pkg::ACT_QUERY, uid);
        if (p == 1 && n == 44) hold_until_drained();
      end
    end

    hold_until_drained();
    if (book.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/rtal_pkg.sv
sv/rtal_if.sv
sv/rtal_table.sv
sv/rfid_tag_allow_list.sv
tb/tb_rfid_tag_allow_list.sv
